/* sv/u8sv_pkg.sv */
package u8sv_pkg;

    localparam int unsigned MAX_TEXT_BYTES = 1048576;
    localparam int unsigned POS_W          = 20;
    localparam int unsigned CP_W           = 21;
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_TEXT_BYTES - 1);

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_LEAD      = 4'd1;
    localparam logic [3:0] ERR_TRUNC     = 4'd2;
    localparam logic [3:0] ERR_CONT      = 4'd3;
    localparam logic [3:0] ERR_OVERLONG  = 4'd4;
    localparam logic [3:0] ERR_SURROGATE = 4'd5;
    localparam logic [3:0] ERR_TOO_LARGE = 4'd6;
    localparam logic [3:0] ERR_NUL       = 4'd7;
    localparam logic [3:0] ERR_CONTROL   = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic            char_complete;
        logic [CP_W-1:0] code_point;
        logic            error_now;
        logic [3:0]      fault_code;
        logic [POS_W-1:0] error_offset;
        logic            text_done;
        logic            text_valid;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0] byte_pos;
        logic [POS_W-1:0] lead_pos;
        logic [1:0]       remaining;
        logic [2:0]       seq_len;
        logic [CP_W-1:0]  acc;
        logic             pend_err;
        logic [POS_W-1:0] pend_pos;
        logic [3:0]       err_code;
        logic [POS_W-1:0] err_pos;
    } dec_state_t;

    function automatic logic [3:0] check_code_point(input logic [CP_W-1:0] cp,
                                                    input logic [2:0] len);
        logic [3:0] res;
        res = ERR_NONE;
        if ((len == 3'd2 && cp < CP_W'(24'h80)) ||
            (len == 3'd3 && cp < CP_W'(24'h800)) ||
            (len == 3'd4 && cp < CP_W'(24'h10000))) begin
            res = ERR_OVERLONG;
        end else if (cp >= CP_W'(24'hd800) && cp <= CP_W'(24'hdfff)) begin
            res = ERR_SURROGATE;
        end else if (cp > CP_W'(24'h10ffff)) begin
            res = ERR_TOO_LARGE;
        end else if (cp == '0) begin
            res = ERR_NUL;
        end else if ((cp < CP_W'(24'h20) && cp != CP_W'(24'h09) && cp != CP_W'(24'h0a) &&
                      cp != CP_W'(24'h0d)) ||
                     (cp >= CP_W'(24'h7f) && cp <= CP_W'(24'h9f))) begin
            res = ERR_CONTROL;
        end
        return res;
    endfunction

endpackage

/* sv/u8sv_step.sv */
module u8sv_step
    import u8sv_pkg::*;
(
    input  dec_state_t cur,
    input  in_item_t   item,
    output dec_state_t nxt,
    output out_item_t  res
);

    logic [7:0]       b;
    logic [2:0]       len;
    logic [CP_W-1:0]  lead_acc;
    logic [1:0]       rem_dec;
    logic [3:0]       code;
    logic [3:0]       chk;
    logic [POS_W-1:0] at;

    assign b = item.data_byte;

    always_comb begin
        nxt      = cur;
        res      = '0;
        len      = 3'd0;
        lead_acc = '0;
        rem_dec  = 2'd0;
        code     = ERR_NONE;
        chk      = ERR_NONE;
        at       = '0;

        if (cur.err_code == ERR_NONE) begin
            if (cur.remaining == 2'd0) begin
                priority if (b <= 8'h7f) begin
                    len      = 3'd1;
                    lead_acc = CP_W'(b);
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    len      = 3'd2;
                    lead_acc = CP_W'(b[4:0]);
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    len      = 3'd3;
                    lead_acc = CP_W'(b[3:0]);
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    len      = 3'd4;
                    lead_acc = CP_W'(b[2:0]);
                end else begin
                    len      = 3'd0;
                end

                if (len == 3'd0) begin
                    code = ERR_LEAD;
                    at   = cur.byte_pos;
                end else if (len == 3'd1) begin
                    chk  = check_code_point(lead_acc, len);
                    code = chk;
                    at   = cur.byte_pos;
                    if (chk == ERR_NONE) begin
                        res.char_complete = 1'b1;
                        res.code_point    = lead_acc;
                    end
                end else if (item.end_of_text) begin
                    code = ERR_TRUNC;
                    at   = cur.byte_pos;
                end else begin
                    nxt.lead_pos  = cur.byte_pos;
                    nxt.seq_len   = len;
                    nxt.remaining = len[1:0] - 2'd1;
                    nxt.acc       = lead_acc;
                    nxt.pend_err  = 1'b0;
                    nxt.pend_pos  = '0;
                end
            end else begin
                if (!cur.pend_err) begin
                    if (b[7:6] != 2'b10) begin
                        nxt.pend_err = 1'b1;
                        nxt.pend_pos = cur.byte_pos;
                    end else begin
                        nxt.acc = {cur.acc[CP_W-7:0], b[5:0]};
                    end
                end
                rem_dec       = cur.remaining - 2'd1;
                nxt.remaining = rem_dec;
                if (rem_dec == 2'd0) begin
                    if (nxt.pend_err) begin
                        code = ERR_CONT;
                        at   = nxt.pend_pos;
                    end else begin
                        chk  = check_code_point(nxt.acc, cur.seq_len);
                        code = chk;
                        at   = cur.lead_pos;
                        if (chk == ERR_NONE) begin
                            res.char_complete = 1'b1;
                            res.code_point    = nxt.acc;
                        end
                    end
                    nxt.seq_len  = 3'd0;
                    nxt.pend_err = 1'b0;
                end else if (item.end_of_text) begin
                    code = ERR_TRUNC;
                    at   = cur.lead_pos;
                end
            end

            if (code != ERR_NONE) begin
                nxt.err_code  = code;
                nxt.err_pos   = at;
                res.error_now = 1'b1;
            end
        end

        if (cur.byte_pos < POS_MAX) begin
            nxt.byte_pos = cur.byte_pos + POS_W'(1);
        end

        res.fault_code   = nxt.err_code;
        res.error_offset = nxt.err_pos;
        res.text_done    = item.end_of_text;
        res.text_valid   = item.end_of_text && (nxt.err_code == ERR_NONE);

        if (item.end_of_text) begin
            nxt = '0;
        end
    end

endmodule

/* sv/utf8_stream_validator_core.sv */
// UTF-8 stream validator: one text byte per item, one result per item. Each byte
// passes an input register, then combinational decode logic into the result
// register, so a byte can be taken every cycle unless the result side stalls.
// The first error and its byte offset are held until the byte flagged end_of_text,
// whose result carries the verdict; all decode state is cleared after that byte.
module utf8_stream_validator_core
    import u8sv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic       in_valid_reg;
    in_item_t   in_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    out_item_t  res_next;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    u8sv_step u_step (
        .cur  (state_reg),
        .item (in_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_reg.end_of_text |=> state_reg == '0)
        else $error("decode state not cleared after end of text");

    a_error_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_reg.end_of_text && state_reg.err_code != ERR_NONE
        |=> state_reg.err_code == $past(state_reg.err_code) &&
            state_reg.err_pos == $past(state_reg.err_pos))
        else $error("latched error changed before end of text");

    a_complete_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.char_complete && out_reg.fault_code != ERR_NONE))
        else $error("character completed while an error is latched");

    a_error_now_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.error_now |-> out_reg.fault_code != ERR_NONE)
        else $error("error reported without an error code");

    a_valid_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.text_valid
        |-> out_reg.text_done && out_reg.fault_code == ERR_NONE)
        else $error("text marked valid with an error or before its end");
`endif

endmodule

/* verif/utf8_stream_validator_core_test.sv */
module utf8_stream_validator_core_test;
    import u8sv_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    utf8_stream_validator_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // decoder state as seen by the predictor
    logic [POS_W-1:0] pos_count   = '0;
    logic [POS_W-1:0] lead_at     = '0;
    logic [1:0]       left_bytes  = '0;
    logic [2:0]       seq_len     = '0;
    logic [CP_W-1:0]  cp_acc      = '0;
    logic             cont_bad    = 1'b0;
    logic [POS_W-1:0] cont_bad_at = '0;
    logic [3:0]       err_kind    = ERR_NONE;
    logic [POS_W-1:0] err_at      = '0;

    out_item_t  expected_results[$];
    logic [7:0] text_bytes[$];
    int         items_sent = 0;
    int         failures   = 0;
    int         hold_req   = 0;
    bit         calm       = 1'b0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("utf8_stream_validator_core_test failed");
        $finish;
    end

    function automatic logic [3:0] point_fault(logic [CP_W-1:0] cp, logic [2:0] len);
        logic [CP_W-1:0] floor_cp;
        case (len)
            3'd2: floor_cp = CP_W'('h80);
            3'd3: floor_cp = CP_W'('h800);
            3'd4: floor_cp = CP_W'('h10000);
            default: floor_cp = '0;
        endcase
        if (cp < floor_cp) return ERR_OVERLONG;
        if (cp >= CP_W'('hd800) && cp <= CP_W'('hdfff)) return ERR_SURROGATE;
        if (cp > CP_W'('h10ffff)) return ERR_TOO_LARGE;
        if (cp == '0) return ERR_NUL;
        if ((cp < CP_W'('h20) && cp != CP_W'('h09) && cp != CP_W'('h0a) &&
             cp != CP_W'('h0d)) || (cp >= CP_W'('h7f) && cp <= CP_W'('h9f)))
            return ERR_CONTROL;
        return ERR_NONE;
    endfunction

    function automatic out_item_t decode_byte(in_item_t it);
        out_item_t        r;
        logic [7:0]       b;
        logic [3:0]       found;
        logic [POS_W-1:0] found_at;
        logic [2:0]       len;
        logic [CP_W-1:0]  first;
        r        = '0;
        b        = it.data_byte;
        found    = ERR_NONE;
        found_at = '0;
        if (err_kind == ERR_NONE) begin
            if (left_bytes == 2'd0) begin
                len   = 3'd0;
                first = '0;
                if (b < 8'h80) begin
                    len   = 3'd1;
                    first = CP_W'(b);
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    len   = 3'd2;
                    first = CP_W'(b[4:0]);
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    len   = 3'd3;
                    first = CP_W'(b[3:0]);
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    len   = 3'd4;
                    first = CP_W'(b[2:0]);
                end
                if (len == 3'd0) begin
                    found    = ERR_LEAD;
                    found_at = pos_count;
                end else if (len == 3'd1) begin
                    found    = point_fault(first, len);
                    found_at = pos_count;
                    if (found == ERR_NONE) begin
                        r.char_complete = 1'b1;
                        r.code_point    = first;
                    end
                end else if (it.end_of_text) begin
                    found    = ERR_TRUNC;
                    found_at = pos_count;
                end else begin
                    lead_at    = pos_count;
                    seq_len    = len;
                    left_bytes = 2'(len - 3'd1);
                    cp_acc     = first;
                    cont_bad   = 1'b0;
                    cont_bad_at = '0;
                end
            end else begin
                if (!cont_bad) begin
                    if (b[7:6] != 2'b10) begin
                        cont_bad    = 1'b1;
                        cont_bad_at = pos_count;
                    end else begin
                        cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
                    end
                end
                left_bytes = left_bytes - 2'd1;
                if (left_bytes == 2'd0) begin
                    if (cont_bad) begin
                        found    = ERR_CONT;
                        found_at = cont_bad_at;
                    end else begin
                        found    = point_fault(cp_acc, seq_len);
                        found_at = lead_at;
                        if (found == ERR_NONE) begin
                            r.char_complete = 1'b1;
                            r.code_point    = cp_acc;
                        end
                    end
                    seq_len  = '0;
                    cont_bad = 1'b0;
                end else if (it.end_of_text) begin
                    found    = ERR_TRUNC;
                    found_at = lead_at;
                end
            end
            if (found != ERR_NONE) begin
                err_kind    = found;
                err_at      = found_at;
                r.error_now = 1'b1;
            end
        end
        if (pos_count < POS_MAX) pos_count = pos_count + POS_W'(1);
        r.fault_code   = err_kind;
        r.error_offset = err_at;
        r.text_done    = it.end_of_text;
        r.text_valid   = it.end_of_text && err_kind == ERR_NONE;
        if (it.end_of_text) begin
            pos_count   = '0;
            lead_at     = '0;
            left_bytes  = '0;
            seq_len     = '0;
            cp_acc      = '0;
            cont_bad    = 1'b0;
            cont_bad_at = '0;
            err_kind    = ERR_NONE;
            err_at      = '0;
        end
        return r;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("char_complete", 32'(want.char_complete),
                                  32'(m_data.char_complete));
                    compare_field("code_point", 32'(want.code_point), 32'(m_data.code_point));
                    compare_field("error_now", 32'(want.error_now), 32'(m_data.error_now));
                    compare_field("fault_code", 32'(want.fault_code), 32'(m_data.fault_code));
                    compare_field("error_offset", 32'(want.error_offset),
                                  32'(m_data.error_offset));
                    compare_field("text_done", 32'(want.text_done), 32'(m_data.text_done));
                    compare_field("text_valid", 32'(want.text_valid), 32'(m_data.text_valid));
                end
            end
            if (s_valid && s_ready) expected_results = {expected_results, decode_byte(s_data)};
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_item(logic [7:0] b, logic last);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 21) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_data.data_byte   <= b;
        s_data.end_of_text <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text();
        foreach (text_bytes[i]) send_item(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic add_byte(logic [7:0] v);
        text_bytes = {text_bytes, v};
    endtask

    task automatic add_char(logic [20:0] cp, int len);
        case (len)
            1: add_byte(cp[7:0]);
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    task automatic add_valid_multibyte(output int len);
        len = $urandom_range(2, 4);
        case (len)
            2: add_char(21'($urandom_range('ha0, 'h7ff)), 2);
            3: add_char(21'($urandom_range('h800, 'hd7ff)), 3);
            default: add_char(21'($urandom_range('h10000, 'h10ffff)), 4);
        endcase
    endtask

    task automatic add_random_char(bit clean);
        int   pick;
        int   len;
        int   k;
        int   r;
        pick = clean ? $urandom_range(84) : $urandom_range(99);
        if (pick < 40) add_char(21'($urandom_range('h20, 'h7e)), 1);
        else if (pick < 45) begin
            r = $urandom_range(2);
            add_char(21'(r == 0 ? 'h09 : (r == 1 ? 'h0a : 'h0d)), 1);
        end
        else if (pick < 60) add_char(21'($urandom_range('h80, 'h7ff)), 2);
        else if (pick < 75) add_char(21'($urandom_range('h800, 'hffff)), 3);
        else if (pick < 85) add_char(21'($urandom_range('h10000, 'h10ffff)), 4);
        else if (pick < 87)
            add_char(21'($urandom_range(3) == 0 ? 'h7f : $urandom_range('h1f)), 1);
        else if (pick < 89) begin
            if ($urandom_range(1)) add_char(21'($urandom_range('h7ff)), 3);
            else add_char(21'($urandom_range('hffff)), 4);
        end
        else if (pick < 90) add_char(21'($urandom_range('hd800, 'hdfff)), 3);
        else if (pick < 91) add_char(21'($urandom_range('h110000, 'h1fffff)), 4);
        else if (pick < 94) add_byte(8'($urandom_range(255)));
        else if (pick < 96) begin
            add_valid_multibyte(len);
            k = text_bytes.size() - $urandom_range(1, len - 1);
            r = $urandom_range(191);
            text_bytes[k] = 8'(r < 128 ? r : r + 64);
        end
        else if (pick < 98) begin
            add_valid_multibyte(len);
            repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
        end
        else add_byte(8'($urandom_range('h80, 'hbf)));
    endtask

    task automatic test_special_cases();
        // tab, LF, CR and the highest code point
        text_bytes = '{8'h09, 8'h0a, 8'h0d, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_text();
        // bad continuation, reported at the bad byte when the sequence ends
        text_bytes = '{8'he0, 8'h41, 8'h80};
        send_text();
        // truncation outranks the bad continuation inside the sequence
        text_bytes = '{8'he0, 8'h41};
        send_text();
        // invalid lead, then ignored bytes
        text_bytes = '{8'hff, 8'h41};
        send_text();
        // stray continuation as the only and last byte
        text_bytes = '{8'h80};
        send_text();
        text_bytes = '{8'hed, 8'ha0, 8'h80};
        send_text();
        text_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
        send_text();
        text_bytes = '{8'h00};
        send_text();
        // C1 control
        text_bytes = '{8'hc2, 8'h80};
        send_text();
    endtask

    task automatic test_random_texts();
        int  start;
        bit  clean;
        start = items_sent;
        while (items_sent - start < 2000) begin
            calm  = (items_sent - start >= 700) && (items_sent - start < 1000);
            clean = $urandom_range(99) < 60;
            text_bytes.delete();
            repeat ($urandom_range(1, 10)) add_random_char(clean);
            send_text();
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        int start;
        start    = items_sent;
        hold_req = 200;
        while (items_sent - start < 80) begin
            text_bytes.delete();
            repeat ($urandom_range(1, 6)) add_random_char(1'b1);
            send_text();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_special_cases();
        test_random_texts();
        test_backpressure();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (failures == 0) begin
            $display("utf8_stream_validator_core_test passed");
        end else begin
            $display("utf8_stream_validator_core_test failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/u8sv_pkg.sv
sv/u8sv_step.sv
sv/utf8_stream_validator_core.sv
verif/utf8_stream_validator_core_test.sv
